/* rtl/core/plm_pkg.sv */
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types, lifecycle codes and transition/aggregation tables for the
// participant lifecycle monitor.
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int SLOT_W    = 4;
  localparam int STATE_W   = 4;
  localparam int MASK_W    = 16;
  localparam int CNT_W     = 32;
  localparam int SLOT_LIMIT = 1 << SLOT_W;
  localparam int MAX_PARTICIPANTS_DEF = 16;

  // lifecycle codes; 10/11 read as coldswap pending/done at system level
  localparam logic [STATE_W-1:0] ST_INVALID    = 4'd0;
  localparam logic [STATE_W-1:0] ST_IDLE       = 4'd1;
  localparam logic [STATE_W-1:0] ST_INITING    = 4'd2;
  localparam logic [STATE_W-1:0] ST_INITED     = 4'd3;
  localparam logic [STATE_W-1:0] ST_RUNNING    = 4'd4;
  localparam logic [STATE_W-1:0] ST_PAUSED     = 4'd5;
  localparam logic [STATE_W-1:0] ST_STOPPING   = 4'd6;
  localparam logic [STATE_W-1:0] ST_STOPPED    = 4'd7;
  localparam logic [STATE_W-1:0] ST_CSW_PREP   = 4'd8;
  localparam logic [STATE_W-1:0] ST_CSW_READY  = 4'd9;
  localparam logic [STATE_W-1:0] ST_CSW_IGN    = 4'd10;
  localparam logic [STATE_W-1:0] ST_CSW_SHDN   = 4'd11;
  localparam logic [STATE_W-1:0] ST_SHUTTING   = 4'd12;
  localparam logic [STATE_W-1:0] ST_SHUTDOWN   = 4'd13;
  localparam logic [STATE_W-1:0] ST_ERROR      = 4'd14;

  typedef struct packed {
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [STATE_W-1:0] wr_data;
    logic               mark_en;
    logic [MASK_W-1:0]  mark_mask;
  } store_cmd_t;

  typedef struct packed {
    logic [STATE_W-1:0] rd_state;
    logic               rd_known;
    logic               mark_hit;
  } store_stat_t;

  typedef struct packed {
    logic               start;
    logic [STATE_W-1:0] s;
    logic [STATE_W-1:0] agg;
    logic               step;
    logic               known;
    logic [STATE_W-1:0] state;
  } chk_cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0] m0;
    logic [MASK_W-1:0] m1;
    logic [MASK_W-1:0] m2;
  } chk_masks_t;

  function automatic logic [MASK_W-1:0] ps(input logic [STATE_W-1:0] x);
    return MASK_W'(1) << x;
  endfunction

  function automatic logic [MASK_W-1:0] allowed_prev(input logic [STATE_W-1:0] ns);
    logic [MASK_W-1:0] m;
    case (ns)
      ST_IDLE:      m = ps(ST_INVALID) | ps(ST_CSW_SHDN);
      ST_INITING:   m = ps(ST_IDLE) | ps(ST_ERROR) | ps(ST_STOPPED) | ps(ST_CSW_IGN);
      ST_INITED:    m = ps(ST_INITING);
      ST_RUNNING:   m = ps(ST_INITED) | ps(ST_PAUSED);
      ST_PAUSED:    m = ps(ST_RUNNING);
      ST_STOPPING:  m = ps(ST_RUNNING) | ps(ST_PAUSED);
      ST_STOPPED:   m = ps(ST_STOPPING);
      ST_CSW_PREP:  m = ps(ST_STOPPED) | ps(ST_ERROR);
      ST_CSW_READY: m = ps(ST_CSW_PREP);
      ST_CSW_IGN:   m = ps(ST_CSW_READY);
      ST_CSW_SHDN:  m = ps(ST_CSW_READY);
      ST_SHUTTING:  m = ps(ST_ERROR) | ps(ST_STOPPED);
      ST_SHUTDOWN:  m = ps(ST_SHUTTING);
      ST_ERROR:     m = '1;
      default:      m = '0;
    endcase
    return m;
  endfunction

  // state sets checked in one pass for a refresh triggered by state s
  function automatic chk_masks_t refresh_masks(input logic [STATE_W-1:0] s,
                                               input logic [STATE_W-1:0] agg);
    chk_masks_t r;
    r = '0;
    case (s)
      ST_IDLE: begin
        if (agg == ST_CSW_IGN) begin
          r.m0 = ps(ST_IDLE) | ps(ST_CSW_IGN);
        end else begin
          r.m0 = ps(ST_IDLE);
          r.m1 = ps(ST_IDLE) | ps(ST_INITING) | ps(ST_INITED);
        end
      end
      ST_INITING: begin
        r.m0 = ps(ST_INITING) | ps(ST_IDLE);
        r.m1 = ps(ST_INITING) | ps(ST_STOPPED) | ps(ST_ERROR);
        r.m2 = ps(ST_INITING) | ps(ST_IDLE) | ps(ST_CSW_IGN);
      end
      ST_INITED:    r.m0 = ps(ST_INITED);
      ST_RUNNING:   r.m0 = ps(ST_RUNNING);
      ST_PAUSED:    r.m0 = ps(ST_PAUSED) | ps(ST_RUNNING);
      ST_STOPPING: begin
        r.m0 = ps(ST_STOPPING) | ps(ST_STOPPED) | ps(ST_PAUSED) | ps(ST_RUNNING);
        r.m1 = ps(ST_STOPPED);
      end
      ST_STOPPED:   r.m0 = ps(ST_STOPPED);
      ST_CSW_PREP:  r.m0 = ps(ST_STOPPED) | ps(ST_CSW_PREP) | ps(ST_CSW_READY) | ps(ST_ERROR);
      ST_CSW_READY: r.m0 = ps(ST_CSW_READY);
      ST_CSW_SHDN:  r.m0 = ps(ST_CSW_READY) | ps(ST_CSW_SHDN) | ps(ST_CSW_IGN);
      ST_CSW_IGN: begin
        r.m0 = ps(ST_CSW_IGN);
        r.m1 = ps(ST_CSW_READY) | ps(ST_CSW_SHDN) | ps(ST_CSW_IGN);
      end
      ST_SHUTTING: begin
        r.m0 = ps(ST_SHUTTING) | ps(ST_SHUTDOWN) | ps(ST_STOPPED) | ps(ST_ERROR) |
               ps(ST_IDLE) | ps(ST_INITED);
        r.m1 = ps(ST_SHUTDOWN);
      end
      ST_SHUTDOWN:  r.m0 = ps(ST_SHUTDOWN);
      default:      r = '0;
    endcase
    return r;
  endfunction

  // new aggregate state from the all-of flags of one pass
  function automatic logic [STATE_W-1:0] refresh_decide(input logic [STATE_W-1:0] s,
                                                        input logic [STATE_W-1:0] agg,
                                                        input logic [2:0] acc);
    logic [STATE_W-1:0] n;
    n = agg;
    case (s)
      ST_IDLE: begin
        if (agg == ST_CSW_IGN) begin
          if (acc[0]) n = ST_CSW_SHDN;
        end else if (acc[0]) begin
          n = ST_IDLE;
        end else if (acc[1]) begin
          n = ST_INITING;
        end
      end
      ST_INITING:   if (|acc) n = ST_INITING;
      ST_INITED:    if (acc[0]) n = ST_INITED;
      ST_RUNNING:   if (acc[0]) n = ST_RUNNING;
      ST_PAUSED:    if (acc[0]) n = ST_PAUSED;
      ST_STOPPING: begin
        if (acc[1]) n = ST_STOPPED;
        else if (acc[0]) n = ST_STOPPING;
      end
      ST_STOPPED:   if (acc[0]) n = ST_STOPPED;
      ST_CSW_PREP:  if (acc[0]) n = ST_CSW_PREP;
      ST_CSW_READY: if (acc[0]) n = ST_CSW_READY;
      ST_CSW_SHDN:  if (acc[0]) n = ST_CSW_IGN;
      ST_CSW_IGN: begin
        if (acc[0]) n = ST_CSW_SHDN;
        else if (acc[1]) n = ST_CSW_IGN;
      end
      ST_SHUTTING: begin
        if (acc[1]) n = ST_SHUTDOWN;
        else if (acc[0]) n = ST_SHUTTING;
      end
      ST_SHUTDOWN:  if (acc[0]) n = ST_SHUTDOWN;
      ST_ERROR:     n = ST_ERROR;
      default:      n = agg;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/plm_slot_store.sv */
// ----------------------------------------------------------------------------
// plm_slot_store
// Per-slot state memory with known and written flags; one registered read.
// ----------------------------------------------------------------------------
module plm_slot_store #(
  parameter int NUM_SLOTS = plm_pkg::MAX_PARTICIPANTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  plm_pkg::store_cmd_t   cmd,
  output plm_pkg::store_stat_t  stat
);
  import plm_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);

  logic [STATE_W-1:0]   mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] known;
  logic [NUM_SLOTS-1:0] written;
  logic [NUM_SLOTS-1:0] mark;
  logic [STATE_W-1:0]   rd_mem;
  logic                 rd_written;
  logic                 rd_known;

  assign mark = cmd.mark_mask[NUM_SLOTS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[IW-1:0]] <= cmd.wr_data;
    end
    rd_mem     <= mem[cmd.rd_addr[IW-1:0]];
    rd_written <= written[cmd.rd_addr[IW-1:0]];
    rd_known   <= known[cmd.rd_addr[IW-1:0]];
  end

  // newly marked slots read as invalid until written
  always_ff @(posedge clk) begin
    if (rst) begin
      known   <= '0;
      written <= '0;
    end else begin
      if (cmd.mark_en) begin
        known   <= known | mark;
        written <= written & ~(mark & ~known);
      end
      if (cmd.wr_en) begin
        known[cmd.wr_addr[IW-1:0]]   <= 1'b1;
        written[cmd.wr_addr[IW-1:0]] <= 1'b1;
      end
    end
  end

  assign stat.rd_state = rd_written ? rd_mem : ST_INVALID;
  assign stat.rd_known = rd_known;
  assign stat.mark_hit = |(mark & known);

endmodule

/* rtl/core/plm_check_unit.sv */
// ----------------------------------------------------------------------------
// plm_check_unit
// Shared all-of checker: tests one slot state a cycle against up to three
// state sets and yields the refreshed system state.
// ----------------------------------------------------------------------------
module plm_check_unit (
  input  logic                        clk,
  input  plm_pkg::chk_cmd_t           cmd,
  output logic [plm_pkg::STATE_W-1:0] agg_next
);
  import plm_pkg::*;

  chk_masks_t         masks;
  logic [STATE_W-1:0] s_l;
  logic [STATE_W-1:0] agg_l;
  logic [2:0]         acc;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      masks <= refresh_masks(cmd.s, cmd.agg);
      s_l   <= cmd.s;
      agg_l <= cmd.agg;
      acc   <= '1;
    end else if (cmd.step && cmd.known) begin
      acc[0] <= acc[0] & masks.m0[cmd.state];
      acc[1] <= acc[1] & masks.m1[cmd.state];
      acc[2] <= acc[2] & masks.m2[cmd.state];
    end
  end

  assign agg_next = refresh_decide(s_l, agg_l, acc);

endmodule

/* rtl/core/participant_lifecycle_monitor.sv */
// ----------------------------------------------------------------------------
// participant_lifecycle_monitor
// Tracks per-slot lifecycle states and the aggregate system state.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): a status update (kind 0) or a load of
// the expected participant set (kind 1). One result transfer per item on
// the output channel (out_valid/out_stall).
// One item at a time; in_stall is high while an item is in work.
// Sequencer states per item, N = min(MAX_PARTICIPANTS, 16):
//   update without system refresh, or ignored: IDLE, UPD, DONE
//   slot out of range, load error, load with no known slot: IDLE, DONE
//   refreshing update: IDLE, UPD, SCAN over N slots, DRAIN, DECIDE, DONE
//   load with refresh: per expected slot LNEXT, LREAD, SCAN, DRAIN, DECIDE
// The refresh is a pass over all N slots through the single read port of
// the slot memory, one slot per cycle into the shared check unit.
// A finished result waits in the output register while out_stall is high;
// the next item may be taken meanwhile, but its result holds in the
// sequencer until that register has been moved out.
// Reset clears all slot states to invalid, the expected set, the system
// state and the invalid-transition count, and drops out_valid.
// ----------------------------------------------------------------------------
module participant_lifecycle_monitor #(
  parameter int MAX_PARTICIPANTS = plm_pkg::MAX_PARTICIPANTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [plm_pkg::SLOT_W-1:0]  participant,
  input  logic [plm_pkg::STATE_W-1:0] new_state,
  input  logic [plm_pkg::MASK_W-1:0]  expected_mask,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        ignored,
  output logic                        transition_ok,
  output logic                        status_changed,
  output logic [plm_pkg::STATE_W-1:0] system_state,
  output logic                        system_changed,
  output logic                        load_error,
  output logic [plm_pkg::CNT_W-1:0]   invalid_count
);
  import plm_pkg::*;

  localparam int NUM_SLOTS = (MAX_PARTICIPANTS < SLOT_LIMIT) ? MAX_PARTICIPANTS : SLOT_LIMIT;
  localparam int IW        = $clog2(NUM_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UPD    = 8'b0000_0010,
    S_LNEXT  = 8'b0000_0100,
    S_LREAD  = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_DRAIN  = 8'b0010_0000,
    S_DECIDE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } seq_t;

  seq_t                 state;
  logic [IW-1:0]        sc;
  logic [IW-1:0]        li;
  logic                 sv;
  logic [NUM_SLOTS-1:0] exp_set;
  logic [STATE_W-1:0]   agg;
  logic [CNT_W-1:0]     cnt;
  logic [STATE_W-1:0]   old_sys;
  logic                 load_mode;
  logic [SLOT_W-1:0]    p_reg;
  logic [STATE_W-1:0]   ns_reg;
  logic                 r_ignored;
  logic                 r_ok;
  logic                 r_changed;
  logic                 r_load_err;

  store_cmd_t           scmd;
  store_stat_t          sstat;
  chk_cmd_t             ccmd;
  logic [STATE_W-1:0]   agg_next;

  logic                 accept;
  logic                 in_range;
  logic [STATE_W-1:0]   old_st;
  logic [MASK_W-1:0]    allowed_m;
  logic                 trans_ok;
  logic                 out_free;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_range  = (int'(participant) < NUM_SLOTS);
  assign old_st    = sstat.rd_state;
  assign allowed_m = allowed_prev(ns_reg);
  assign trans_ok  = allowed_m[old_st];
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    scmd           = '0;
    scmd.wr_addr   = p_reg;
    scmd.wr_data   = ns_reg;
    scmd.mark_mask = expected_mask;
    case (state)
      S_IDLE: begin
        scmd.rd_addr = participant;
        scmd.mark_en = accept && kind && (exp_set == '0);
      end
      S_UPD:   scmd.wr_en   = (old_st != ST_SHUTDOWN);
      S_LNEXT: scmd.rd_addr = SLOT_W'(li);
      S_SCAN:  scmd.rd_addr = SLOT_W'(sc);
      default: scmd.rd_addr = '0;
    endcase
  end

  always_comb begin
    ccmd       = '0;
    ccmd.agg   = agg;
    ccmd.step  = sv;
    ccmd.known = sstat.rd_known;
    ccmd.state = sstat.rd_state;
    case (state)
      S_UPD: begin
        ccmd.start = 1'b1;
        ccmd.s     = ns_reg;
      end
      S_LREAD: begin
        ccmd.start = 1'b1;
        ccmd.s     = sstat.rd_state;
      end
      default: ccmd.start = 1'b0;
    endcase
  end

  plm_slot_store #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .cmd  (scmd),
    .stat (sstat)
  );

  plm_check_unit u_check (
    .clk      (clk),
    .cmd      (ccmd),
    .agg_next (agg_next)
  );

  always_ff @(posedge clk) begin
    sv <= (state == S_SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      exp_set   <= '0;
      agg       <= ST_INVALID;
      cnt       <= '0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            old_sys    <= agg;
            load_mode  <= kind;
            p_reg      <= participant;
            ns_reg     <= new_state;
            r_ignored  <= 1'b0;
            r_ok       <= 1'b0;
            r_changed  <= 1'b0;
            r_load_err <= kind && (exp_set != '0);
            li         <= '0;
            if (kind) begin
              if (exp_set != '0) begin
                state <= S_DONE;
              end else begin
                exp_set <= expected_mask[NUM_SLOTS-1:0];
                state   <= sstat.mark_hit ? S_LNEXT : S_DONE;
              end
            end else begin
              state <= in_range ? S_UPD : S_DONE;
            end
          end
        end
        S_UPD: begin
          r_ok <= trans_ok;
          if (!trans_ok) begin
            cnt <= cnt + CNT_W'(1);
          end
          sc <= '0;
          if (old_st == ST_SHUTDOWN) begin
            r_ignored <= 1'b1;
            state     <= S_DONE;
          end else if (old_st != ns_reg) begin
            r_changed <= 1'b1;
            state     <= exp_set[p_reg[IW-1:0]] ? S_SCAN : S_DONE;
          end else begin
            state <= S_DONE;
          end
        end
        S_LNEXT: begin
          if (exp_set[li]) begin
            state <= S_LREAD;
          end else if (li == LAST) begin
            state <= S_DONE;
          end else begin
            li <= li + IW'(1);
          end
        end
        S_LREAD: begin
          sc    <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (sc == LAST) begin
            state <= S_DRAIN;
          end else begin
            sc <= sc + IW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          agg <= agg_next;
          if (load_mode && (li != LAST)) begin
            li    <= li + IW'(1);
            state <= S_LNEXT;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            ignored        <= r_ignored;
            transition_ok  <= r_ok;
            status_changed <= r_changed;
            system_state   <= agg;
            system_changed <= (agg != old_sys);
            load_error     <= r_load_err;
            invalid_count  <= cnt;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for participant_lifecycle_monitor. A scoreboard class
// tracks slot states, the expected set and the system state, predicts one
// result per input transfer and compares each output transfer against it.
// Stimulus is a directed opening, then lockstep lifecycle rounds over the
// known slots mixed with random noise updates and repeated loads, under
// three source/sink throttling profiles, and a shutdown tail.
// ----------------------------------------------------------------------------
module testbench;
  import plm_pkg::*;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;
  localparam logic [STATE_W-1:0] ST_UNUSED = 4'd15;
  localparam int RANDOM_ITEMS = 1590;

  typedef struct packed {
    logic               ign;
    logic               trans_ok;
    logic               slot_chg;
    logic [STATE_W-1:0] sys;
    logic               sys_chg;
    logic               load_err;
    logic [CNT_W-1:0]   bad_cnt;
  } lifecycle_result_t;

  class lifecycle_scoreboard;
    logic [STATE_W-1:0] slot_state [SLOT_LIMIT];
    bit                 slot_known [SLOT_LIMIT];
    logic [MASK_W-1:0]  expected_set;
    logic [STATE_W-1:0] system_now;
    logic [CNT_W-1:0]   bad_total;
    lifecycle_result_t  pending_q[$];
    int unsigned        mismatches;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i] = ST_INVALID;
        slot_known[i] = 1'b0;
      end
      expected_set = '0;
      system_now = ST_INVALID;
      bad_total = '0;
      mismatches = 0;
    endfunction

    function logic [MASK_W-1:0] st_bit(input logic [STATE_W-1:0] s);
      return MASK_W'(1) << s;
    endfunction

    // states from which a report of ns is a legal transition
    function logic [MASK_W-1:0] legal_from(input logic [STATE_W-1:0] ns);
      case (ns)
        ST_IDLE:      return st_bit(ST_INVALID) | st_bit(ST_CSW_SHDN);
        ST_INITING:   return st_bit(ST_IDLE) | st_bit(ST_ERROR) | st_bit(ST_STOPPED) |
                             st_bit(ST_CSW_IGN);
        ST_INITED:    return st_bit(ST_INITING);
        ST_RUNNING:   return st_bit(ST_INITED) | st_bit(ST_PAUSED);
        ST_PAUSED:    return st_bit(ST_RUNNING);
        ST_STOPPING:  return st_bit(ST_RUNNING) | st_bit(ST_PAUSED);
        ST_STOPPED:   return st_bit(ST_STOPPING);
        ST_CSW_PREP:  return st_bit(ST_STOPPED) | st_bit(ST_ERROR);
        ST_CSW_READY: return st_bit(ST_CSW_PREP);
        ST_CSW_IGN:   return st_bit(ST_CSW_READY);
        ST_CSW_SHDN:  return st_bit(ST_CSW_READY);
        ST_SHUTTING:  return st_bit(ST_ERROR) | st_bit(ST_STOPPED);
        ST_SHUTDOWN:  return st_bit(ST_SHUTTING);
        ST_ERROR:     return '1;
        default:      return '0;
      endcase
    endfunction

    function bit all_in(input logic [MASK_W-1:0] states);
      for (int i = 0; i < SLOT_LIMIT; i++) begin
        if (slot_known[i] && !states[slot_state[i]]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void refresh(input logic [STATE_W-1:0] s);
      case (s)
        ST_IDLE: begin
          if (system_now == ST_CSW_IGN) begin
            if (all_in(st_bit(ST_IDLE) | st_bit(ST_CSW_IGN))) system_now = ST_CSW_SHDN;
          end else if (all_in(st_bit(ST_IDLE))) begin
            system_now = ST_IDLE;
          end else if (all_in(st_bit(ST_IDLE) | st_bit(ST_INITING) | st_bit(ST_INITED))) begin
            system_now = ST_INITING;
          end
        end
        ST_INITING: begin
          if (all_in(st_bit(ST_INITING) | st_bit(ST_IDLE)) ||
              all_in(st_bit(ST_INITING) | st_bit(ST_STOPPED) | st_bit(ST_ERROR)) ||
              all_in(st_bit(ST_INITING) | st_bit(ST_IDLE) | st_bit(ST_CSW_IGN)))
            system_now = ST_INITING;
        end
        ST_INITED:    if (all_in(st_bit(ST_INITED))) system_now = ST_INITED;
        ST_RUNNING:   if (all_in(st_bit(ST_RUNNING))) system_now = ST_RUNNING;
        ST_PAUSED:    if (all_in(st_bit(ST_PAUSED) | st_bit(ST_RUNNING))) system_now = ST_PAUSED;
        ST_STOPPING: begin
          if (all_in(st_bit(ST_STOPPING) | st_bit(ST_STOPPED) | st_bit(ST_PAUSED) |
                     st_bit(ST_RUNNING)))
            system_now = ST_STOPPING;
          if (all_in(st_bit(ST_STOPPED))) system_now = ST_STOPPED;
        end
        ST_STOPPED:   if (all_in(st_bit(ST_STOPPED))) system_now = ST_STOPPED;
        ST_CSW_PREP: begin
          if (all_in(st_bit(ST_STOPPED) | st_bit(ST_CSW_PREP) | st_bit(ST_CSW_READY) |
                     st_bit(ST_ERROR)))
            system_now = ST_CSW_PREP;
        end
        ST_CSW_READY: if (all_in(st_bit(ST_CSW_READY))) system_now = ST_CSW_READY;
        ST_CSW_SHDN: begin
          if (all_in(st_bit(ST_CSW_READY) | st_bit(ST_CSW_SHDN) | st_bit(ST_CSW_IGN)))
            system_now = ST_CSW_IGN;
        end
        ST_CSW_IGN: begin
          if (all_in(st_bit(ST_CSW_IGN))) begin
            system_now = ST_CSW_SHDN;
          end else if (all_in(st_bit(ST_CSW_READY) | st_bit(ST_CSW_SHDN) |
                              st_bit(ST_CSW_IGN))) begin
            system_now = ST_CSW_IGN;
          end
        end
        ST_SHUTTING: begin
          if (all_in(st_bit(ST_SHUTTING) | st_bit(ST_SHUTDOWN) | st_bit(ST_STOPPED) |
                     st_bit(ST_ERROR) | st_bit(ST_IDLE) | st_bit(ST_INITED)))
            system_now = ST_SHUTTING;
          if (all_in(st_bit(ST_SHUTDOWN))) system_now = ST_SHUTDOWN;
        end
        ST_SHUTDOWN:  if (all_in(st_bit(ST_SHUTDOWN))) system_now = ST_SHUTDOWN;
        ST_ERROR:     system_now = ST_ERROR;
        default:      ;
      endcase
    endfunction

    function void note_input(input logic k, input logic [SLOT_W-1:0] p,
                             input logic [STATE_W-1:0] s, input logic [MASK_W-1:0] m);
      lifecycle_result_t r;
      logic [STATE_W-1:0] prior_sys;
      logic [STATE_W-1:0] prior;
      logic [MASK_W-1:0]  legal;
      bit                 any_known;
      r = '0;
      prior_sys = system_now;
      if (k == KIND_LOAD) begin
        if (expected_set != '0) begin
          r.load_err = 1'b1;
        end else begin
          any_known = 1'b0;
          expected_set = m;
          for (int i = 0; i < SLOT_LIMIT; i++) begin
            if (m[i]) begin
              if (slot_known[i]) begin
                any_known = 1'b1;
              end else begin
                slot_known[i] = 1'b1;
                slot_state[i] = ST_INVALID;
              end
            end
          end
          if (any_known) begin
            for (int i = 0; i < SLOT_LIMIT; i++) begin
              if (expected_set[i]) refresh(slot_state[i]);
            end
          end
        end
      end else begin
        prior = slot_known[p] ? slot_state[p] : ST_INVALID;
        slot_known[p] = 1'b1;
        legal = legal_from(s);
        if (legal[prior]) r.trans_ok = 1'b1;
        else bad_total++;
        if (prior == ST_SHUTDOWN) begin
          r.ign = 1'b1;
        end else begin
          slot_state[p] = s;
          if (prior != s) begin
            r.slot_chg = 1'b1;
            if (expected_set[p]) refresh(s);
          end
        end
      end
      r.sys = system_now;
      r.sys_chg = (system_now != prior_sys);
      r.bad_cnt = bad_total;
      pending_q.push_back(r);
    endfunction

    function void check_result(input logic ign, input logic trans_ok, input logic slot_chg,
                               input logic [STATE_W-1:0] sys, input logic sys_chg,
                               input logic load_err, input logic [CNT_W-1:0] bad_cnt);
      lifecycle_result_t got;
      lifecycle_result_t want;
      got = '{ign, trans_ok, slot_chg, sys, sys_chg, load_err, bad_cnt};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transfer with nothing expected");
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch (exp/got): ign %0b/%0b ok %0b/%0b chg %0b/%0b sys %0d/%0d",
                 want.ign, got.ign, want.trans_ok, got.trans_ok, want.slot_chg,
                 got.slot_chg, want.sys, got.sys);
          $display(" sys_chg %0b/%0b load_err %0b/%0b count %0d/%0d",
                   want.sys_chg, got.sys_chg, want.load_err, got.load_err,
                   want.bad_cnt, got.bad_cnt);
        end
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [SLOT_W-1:0] participant = '0;
  logic [STATE_W-1:0] new_state = '0;
  logic [MASK_W-1:0] expected_mask = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ignored;
  logic transition_ok;
  logic status_changed;
  logic [STATE_W-1:0] system_state;
  logic system_changed;
  logic load_error;
  logic [CNT_W-1:0] invalid_count;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int sent = 0;
  lifecycle_scoreboard sb = new();

  participant_lifecycle_monitor u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .participant(participant), .new_state(new_state),
    .expected_mask(expected_mask),
    .out_valid(out_valid), .out_stall(out_stall),
    .ignored(ignored), .transition_ok(transition_ok), .status_changed(status_changed),
    .system_state(system_state), .system_changed(system_changed),
    .load_error(load_error), .invalid_count(invalid_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(ignored, transition_ok, status_changed, system_state,
                        system_changed, load_error, invalid_count);
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  task automatic send_item(input logic k, input logic [SLOT_W-1:0] p,
                           input logic [STATE_W-1:0] s, input logic [MASK_W-1:0] m);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    participant <= p;
    new_state <= s;
    expected_mask <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(k, p, s, m);
    sent++;
  endtask

  // hold off the source until every outstanding result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // move known slots to one target state, in random slot order; if partial, about one slot in twenty is skipped
  task automatic lockstep_round(input logic [STATE_W-1:0] target, input bit partial);
    int order[$];
    int pick;
    int held;
    for (int i = 0; i < SLOT_LIMIT; i++) begin
      if (sb.slot_known[i]) order.push_back(i);
    end
    for (int i = order.size() - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      held = order[i];
      order[i] = order[pick];
      order[pick] = held;
    end
    foreach (order[i]) begin
      if (partial && $urandom_range(19) == 0) continue;
      send_item(KIND_UPDATE, SLOT_W'(order[i]), target, MASK_W'($urandom));
    end
  endtask

  function automatic logic [STATE_W-1:0] next_target(input logic [STATE_W-1:0] cur);
    logic [STATE_W-1:0] ns;
    logic [MASK_W-1:0]  legal;
    do begin
      ns = STATE_W'($urandom_range(15));
      legal = sb.legal_from(ns);
    end while (ns == ST_SHUTDOWN || !legal[cur]);
    return ns;
  endfunction

  initial begin
    logic [STATE_W-1:0] cur;
    logic [STATE_W-1:0] s;
    int stop_at;
    int roll;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 15;
    sink_stall_pct = 64;

    // directed opening
    send_item(KIND_UPDATE, 4'd0, ST_IDLE, 16'h0000);
    send_item(KIND_UPDATE, 4'd7, ST_IDLE, 16'hFFFF);
    send_item(KIND_UPDATE, 4'd15, ST_UNUSED, 16'h0000);
    send_item(KIND_UPDATE, 4'd15, ST_INVALID, 16'hFFFF);
    send_item(KIND_LOAD, 4'd15, ST_UNUSED, 16'h0000);
    send_item(KIND_LOAD, 4'd0, ST_INVALID, 16'hA5C3);
    send_item(KIND_LOAD, 4'd15, ST_UNUSED, 16'hFFFF);
    send_item(KIND_LOAD, 4'd0, ST_INVALID, 16'h0000);
    send_item(KIND_UPDATE, 4'd1, ST_ERROR, 16'h0000);
    send_item(KIND_UPDATE, 4'd1, ST_ERROR, 16'h0000);
    send_item(KIND_UPDATE, 4'd2, ST_RUNNING, 16'h0000);
    send_item(KIND_UPDATE, 4'd0, ST_INITING, 16'h0000);
    drain();

    cur = ST_ERROR;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 15;
          sink_stall_pct = 64;
        end
        1: begin
          src_idle_pct = 64;
          sink_stall_pct = 15;
        end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      stop_at = sent + RANDOM_ITEMS / 3;
      while (sent < stop_at) begin
        roll = $urandom_range(99);
        if (roll < 75) begin
          cur = next_target(cur);
          lockstep_round(cur, 1'b1);
        end else if (roll < 95) begin
          repeat ($urandom_range(1, 3)) begin
            s = STATE_W'($urandom_range(15));
            if (s == ST_SHUTDOWN) s = ST_UNUSED;
            send_item(KIND_UPDATE, SLOT_W'($urandom), s, MASK_W'($urandom));
          end
        end else if (roll < 98) begin
          send_item(KIND_LOAD, SLOT_W'($urandom), STATE_W'($urandom), MASK_W'($urandom));
        end else begin
          drain();
        end
      end
      drain();
    end

    // shutdown tail: once a slot is down its later reports are dropped
    lockstep_round(ST_ERROR, 1'b0);
    lockstep_round(ST_SHUTTING, 1'b0);
    lockstep_round(ST_SHUTDOWN, 1'b0);
    send_item(KIND_UPDATE, 4'd0, ST_IDLE, 16'h0000);
    send_item(KIND_UPDATE, 4'd15, ST_SHUTDOWN, 16'h0000);
    send_item(KIND_UPDATE, 4'd7, ST_ERROR, 16'h0000);
    drain();

    repeat (400) @(posedge clk);
    if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
